// ===== hdl/drcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drcs_pkg
// Types and constants shared by the disc read chunk sequencer.
// ----------------------------------------------------------------------------
package drcs_pkg;

    localparam int LBA_W     = 23;
    localparam int RETRY_W   = 4;
    localparam int CSTEP_W   = 12;

    localparam logic [11:0] SEC_BYTES = 12'h800;
    localparam logic [22:0] CHUNK_MAX = 23'h7F8000;
    localparam logic [24:0] DMA_END   = 25'h1800000;

    // request codes
    localparam logic MODE_START    = 1'b0;
    localparam logic MODE_COMPLETE = 1'b1;

    // configuration register indexes
    localparam logic [0:0] CFG_BASE      = 1'b0;
    localparam logic [0:0] CFG_UNSHIFTED = 1'b1;

    localparam logic [7:0] STATUS_CONTINUE = 8'h01;

    typedef enum logic [2:0] {
        ACT_BOUNCE   = 3'd0,
        ACT_DIRECT   = 3'd1,
        ACT_FINISHED = 3'd2,
        ACT_REJECTED = 3'd3,
        ACT_IGNORED  = 3'd4
    } action_t;

    typedef struct packed {
        logic        mode;
        logic [31:0] dest_address;
        logic [31:0] request_length;
        logic [31:0] disc_offset;
        logic [7:0]  drive_status;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  action;
        logic        is_retry;
        logic [31:0] cmd_dest_address;
        logic [22:0] cmd_lba;
        logic [22:0] cmd_byte_count;
        logic [10:0] copy_offset;
        logic [11:0] copy_count;
        logic [7:0]  final_status;
    } out_item_t;

    // one planned drive command plus the bookkeeping it implies
    typedef struct packed {
        logic               direct;
        logic [22:0]        byte_count;
        logic [10:0]        copy_offset;
        logic [11:0]        copy_count;
        logic [22:0]        consumed;
        logic [CSTEP_W-1:0] sector_step;
    } chunk_plan_t;

endpackage
`default_nettype wire

// ===== hdl/drcs_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drcs_stream_if
// Valid/ready channel carrying one item payload.
// ----------------------------------------------------------------------------
interface drcs_stream_if #(
    parameter type payload_t = logic [0:0]
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hdl/drcs_cmd_calc.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drcs_cmd_calc
// Plans the next drive command: direct DMA or one-sector bounce read.
// ----------------------------------------------------------------------------
module drcs_cmd_calc (
    input  wire logic [31:0]  mem,
    input  wire logic [31:0]  remain,
    input  wire logic [22:0]  sector,
    input  wire logic [31:0]  start_word,
    output drcs_pkg::chunk_plan_t plan
);
    logic [27:0] phys;
    logic        aligned;
    logic        in_win;
    logic [24:0] win;
    logic        win_ok;
    logic [22:0] blk_cap;
    logic [24:0] n_sel;
    logic [22:0] dlen;
    logic        dma_ok;
    logic        hit;
    logic [10:0] pos;
    logic [23:0] sum;
    logic [11:0] cnt;
    logic        bstep;

    always_comb
    begin
        phys    = mem[27:0];
        aligned = (phys[4:0] == 5'd0);
        in_win  = (phys < {3'b000, drcs_pkg::DMA_END});
        win     = drcs_pkg::DMA_END - phys[24:0];
        win_ok  = (win > 25'(drcs_pkg::SEC_BYTES));
        blk_cap = (remain > {9'd0, drcs_pkg::CHUNK_MAX}) ? drcs_pkg::CHUNK_MAX : remain[22:0];
        n_sel   = (win < {2'b00, blk_cap}) ? win : {2'b00, blk_cap};
        dlen    = {n_sel[22:11], 11'd0};
        dma_ok  = aligned && in_win && win_ok && (n_sel[22:11] != 12'd0);

        // skip inside the sector only when the start word lies in it
        hit = (start_word[31:9] == sector) && (start_word[8:0] != 9'd0);
        pos = hit ? {start_word[8:0], 2'b00} : 11'd0;

        sum = {1'b0, blk_cap} + {13'd0, pos};
        if (sum > 24'(drcs_pkg::SEC_BYTES))
        begin
            cnt   = drcs_pkg::SEC_BYTES - {1'b0, pos};
            bstep = 1'b1;
        end
        else
        begin
            cnt   = blk_cap[11:0];
            bstep = (sum == 24'(drcs_pkg::SEC_BYTES));
        end

        plan.direct = dma_ok && !hit;
        if (plan.direct)
        begin
            plan.byte_count  = dlen;
            plan.copy_offset = 11'd0;
            plan.copy_count  = 12'd0;
            plan.consumed    = dlen;
            plan.sector_step = dlen[22:11];
        end
        else
        begin
            plan.byte_count  = 23'(drcs_pkg::SEC_BYTES);
            plan.copy_offset = pos;
            plan.copy_count  = cnt;
            plan.consumed    = {11'd0, cnt};
            plan.sector_step = {11'd0, bstep};
        end
    end

endmodule
`default_nettype wire

// ===== hdl/drcs_seq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drcs_seq_ctrl
// Transfer state, configuration and per-item decision logic.
// ----------------------------------------------------------------------------
module drcs_seq_ctrl #(
    parameter int MAX_RETRIES = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [0:0]          cfg_index,
    input  wire logic [31:0]         cfg_wdata,
    input  wire logic                fire,
    input  wire drcs_pkg::in_item_t  item,
    output drcs_pkg::out_item_t      result
);
    localparam logic [drcs_pkg::RETRY_W-1:0] RetryLimit = drcs_pkg::RETRY_W'(MAX_RETRIES);

    logic [31:0] base_reg;
    logic        unshifted_reg;

    logic        busy_reg, busy_next;
    logic [drcs_pkg::RETRY_W-1:0] retry_reg, retry_next;

    logic [31:0] mem_reg, mem_next;
    logic [31:0] remain_reg, remain_next;
    logic [22:0] sector_reg, sector_next;
    logic [31:0] start_word_reg, start_word_next;
    logic        issue;

    logic [31:0] last_address_reg;
    logic [22:0] last_lba_reg;
    drcs_pkg::chunk_plan_t last_plan_reg;

    logic [31:0] word;
    logic        is_start;
    logic [31:0] mem_in;
    logic [31:0] remain_in;
    logic [22:0] sector_in;
    logic [31:0] start_word_in;
    drcs_pkg::chunk_plan_t plan;

    always_comb
    begin
        word          = base_reg + (unshifted_reg ? item.disc_offset
                                                  : {2'b00, item.disc_offset[31:2]});
        is_start      = (item.mode == drcs_pkg::MODE_START);
        mem_in        = is_start ? item.dest_address   : mem_reg;
        remain_in     = is_start ? item.request_length : remain_reg;
        sector_in     = is_start ? word[31:9]          : sector_reg;
        start_word_in = is_start ? word                : start_word_reg;
    end

    drcs_cmd_calc u_calc (
        .mem        (mem_in),
        .remain     (remain_in),
        .sector     (sector_in),
        .start_word (start_word_in),
        .plan       (plan)
    );

    always_comb
    begin
        result          = '0;
        busy_next       = busy_reg;
        retry_next      = retry_reg;
        issue           = 1'b0;
        mem_next        = mem_in + {9'd0, plan.consumed};
        remain_next     = remain_in - {9'd0, plan.consumed};
        sector_next     = sector_in + {11'd0, plan.sector_step};
        start_word_next = start_word_in;

        if (is_start)
        begin
            if (busy_reg)
            begin
                result.action = drcs_pkg::ACT_REJECTED;
            end
            else if (remain_in == 32'd0)
            begin
                result.action       = drcs_pkg::ACT_FINISHED;
                result.final_status = drcs_pkg::STATUS_CONTINUE;
            end
            else
            begin
                busy_next = 1'b1;
                issue     = 1'b1;
            end
        end
        else if (!busy_reg)
        begin
            result.action = drcs_pkg::ACT_IGNORED;
        end
        else if (item.drive_status[0])
        begin
            if (remain_in != 32'd0 && item.drive_status == drcs_pkg::STATUS_CONTINUE)
            begin
                issue = 1'b1;
            end
            else
            begin
                busy_next           = 1'b0;
                result.action       = drcs_pkg::ACT_FINISHED;
                result.final_status = item.drive_status;
            end
        end
        else if (retry_reg >= RetryLimit)
        begin
            busy_next           = 1'b0;
            result.action       = drcs_pkg::ACT_FINISHED;
            result.final_status = item.drive_status;
        end
        else
        begin
            // resend the previous command
            retry_next              = retry_reg + {{(drcs_pkg::RETRY_W-1){1'b0}}, 1'b1};
            result.action           = last_plan_reg.direct ? drcs_pkg::ACT_DIRECT
                                                           : drcs_pkg::ACT_BOUNCE;
            result.is_retry         = 1'b1;
            result.cmd_dest_address = last_address_reg;
            result.cmd_lba          = last_lba_reg;
            result.cmd_byte_count   = last_plan_reg.byte_count;
            result.copy_offset      = last_plan_reg.copy_offset;
            result.copy_count       = last_plan_reg.copy_count;
        end

        if (issue)
        begin
            retry_next              = '0;
            result.action           = plan.direct ? drcs_pkg::ACT_DIRECT
                                                  : drcs_pkg::ACT_BOUNCE;
            result.cmd_dest_address = mem_in;
            result.cmd_lba          = sector_in;
            result.cmd_byte_count   = plan.byte_count;
            result.copy_offset      = plan.copy_offset;
            result.copy_count       = plan.copy_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            unshifted_reg <= 1'b0;
            busy_reg      <= 1'b0;
            retry_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    drcs_pkg::CFG_BASE:      base_reg      <= cfg_wdata;
                    drcs_pkg::CFG_UNSHIFTED: unshifted_reg <= cfg_wdata[0];
                endcase
            end
            if (fire)
            begin
                busy_reg  <= busy_next;
                retry_reg <= retry_next;
            end
        end
    end

    // transfer bookkeeping, only read while busy
    always_ff @(posedge clk)
    begin
        if (fire && issue)
        begin
            mem_reg          <= mem_next;
            remain_reg       <= remain_next;
            sector_reg       <= sector_next;
            start_word_reg   <= start_word_next;
            last_address_reg <= mem_in;
            last_lba_reg     <= sector_in;
            last_plan_reg    <= plan;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/disc_read_chunk_sequencer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// disc_read_chunk_sequencer_core
// Splits disc read requests into drive commands and sequences completions.
// ----------------------------------------------------------------------------
// Takes one item per clock on req and returns exactly one result item per
// input item on rsp, via the input register, then decision logic into the
// result register. A start item (mode 0) plans the first drive command of a
// read: a direct DMA read when the target is 32-byte aligned below the window
// end 0x01800000 with over a sector of room and no start-word skip (capped
// at 0x7f8000 bytes, whole sectors), otherwise a one-sector bounce read with
// copy_offset/copy_count for the consumer. A completion item (mode 1) with
// status 1 issues the next command or finishes; other odd statuses finish
// with that status; even statuses resend the last command up to MAX_RETRIES
// times. Starts while busy are rejected, completions while idle are ignored.
// The single decision stage sets the rate, one item per cycle; req stalls
// only when the input and result registers both hold items rsp has not taken.
// disc_base_offset (index 0) and offset_unshifted (index 1) are written on the
// cfg port; the user must do so only while idle, as the block does not check.
// ----------------------------------------------------------------------------
module disc_read_chunk_sequencer_core #(
    parameter int MAX_RETRIES = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    drcs_stream_if.sink      req,
    drcs_stream_if.source    rsp,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata
);
    drcs_pkg::in_item_t  in_item_reg;
    logic                in_valid_reg;
    drcs_pkg::out_item_t out_item_reg;
    logic                out_valid_reg;

    drcs_pkg::out_item_t result;
    logic                fire;

    // the held item moves on when the result slot is free or being emptied
    assign fire      = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || fire;

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_item_reg;

    drcs_seq_ctrl #(
        .MAX_RETRIES (MAX_RETRIES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .item      (in_item_reg),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_item_reg <= req.payload;
        end
        if (fire)
        begin
            out_item_reg <= result;
        end
    end

endmodule
`default_nettype wire

// ===== bench/drcs_read_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drcs_read_checker
// Result predictor and in-order comparator for the disc read sequencer.
// ----------------------------------------------------------------------------
// Tracks configuration writes and accepted request items, works out the one
// result item each request causes, and checks every accepted result item
// field by field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module drcs_read_checker
    import drcs_pkg::*;
#(
    parameter int MAX_RETRIES = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    input  wire logic        req_ready,
    input  wire in_item_t    req_item,
    input  wire logic        rsp_valid,
    input  wire logic        rsp_ready,
    input  wire out_item_t   rsp_item,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata,
    output int unsigned      mismatches,
    output int unsigned      awaited,
    output logic             read_open,
    output int unsigned      direct_cmds,
    output int unsigned      bounce_cmds,
    output int unsigned      resent_cmds,
    output int unsigned      finished_reads
);

    // register copies
    logic [31:0] base_words;
    logic        offs_in_words;

    // read in progress
    logic        rd_busy;
    logic [31:0] dst_base;
    logic [31:0] req_bytes;
    logic [31:0] bytes_issued;
    logic [31:0] first_word;
    logic [22:0] cur_sector;
    out_item_t   prev_cmd;
    logic [3:0]  resend_count;

    out_item_t   result_q[$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch %s: got %h want %h", $time, what, got, want);
        mismatches = mismatches + 1;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // bytes a direct transfer may move to mem, 0 when DMA is not allowed
    function automatic logic [31:0] dma_span(input logic [31:0] mem,
                                             input logic [31:0] size);
        logic [31:0] phys;
        logic [31:0] win;
        logic [31:0] n;
        phys = mem & 32'h0FFF_FFFF;
        if (phys[4:0] != 5'd0 || phys >= 32'(DMA_END))
            return 32'd0;
        win = 32'(DMA_END) - phys;
        if (win <= 32'(SEC_BYTES))
            return 32'd0;
        n = (win < size) ? win : size;
        return {n[31:11], 11'd0};
    endfunction

    function automatic out_item_t close_read(input logic [7:0] status);
        out_item_t r;
        r = '0;
        rd_busy = 1'b0;
        r.action = ACT_FINISHED;
        r.final_status = status;
        return r;
    endfunction

    function automatic out_item_t next_command(input logic [7:0] status);
        logic [31:0] mem;
        logic [31:0] chunk;
        logic [31:0] sect_word;
        logic [31:0] skip;
        logic [31:0] span;
        out_item_t   r;
        if (!(bytes_issued < req_bytes && status == STATUS_CONTINUE))
            return close_read(status);
        mem = dst_base + bytes_issued;
        chunk = req_bytes - bytes_issued;
        sect_word = {cur_sector, 9'd0};
        skip = 32'd0;
        // skip only when the first word sits inside the current sector
        if (first_word > sect_word && (first_word - sect_word) < 32'd512)
            skip = (first_word - sect_word) << 2;
        if (chunk > 32'(CHUNK_MAX))
            chunk = 32'(CHUNK_MAX);
        span = dma_span(mem, chunk);
        r = '0;
        r.cmd_dest_address = mem;
        r.cmd_lba = cur_sector;
        if (span == 32'd0 || skip != 32'd0) begin
            if (chunk + skip > 32'(SEC_BYTES))
                chunk = 32'(SEC_BYTES) - skip;
            r.action = ACT_BOUNCE;
            r.cmd_byte_count = 23'(SEC_BYTES);
            r.copy_offset = skip[10:0];
            r.copy_count = chunk[11:0];
            bytes_issued = bytes_issued + chunk;
            cur_sector = cur_sector + 23'((chunk + skip) >> 11);
        end
        else begin
            r.action = ACT_DIRECT;
            r.cmd_byte_count = span[22:0];
            bytes_issued = bytes_issued + span;
            cur_sector = cur_sector + 23'(span >> 11);
        end
        prev_cmd = r;
        resend_count = 4'd0;
        return r;
    endfunction

    function automatic out_item_t predict_result(input in_item_t it);
        logic [31:0] word;
        out_item_t   r;
        r = '0;
        if (it.mode == MODE_START) begin
            if (rd_busy) begin
                r.action = ACT_REJECTED;
                return r;
            end
            word = base_words + (offs_in_words ? it.disc_offset : (it.disc_offset >> 2));
            rd_busy = 1'b1;
            dst_base = it.dest_address;
            req_bytes = it.request_length;
            bytes_issued = 32'd0;
            first_word = word;
            cur_sector = word[31:9];
            return next_command(STATUS_CONTINUE);
        end
        if (!rd_busy) begin
            r.action = ACT_IGNORED;
            return r;
        end
        if (it.drive_status[0])
            return next_command(it.drive_status);
        if (int'(resend_count) >= MAX_RETRIES)
            return close_read(it.drive_status);
        resend_count = resend_count + 4'd1;
        r = prev_cmd;
        r.is_retry = 1'b1;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n) begin
            base_words = '0;
            offs_in_words = 1'b0;
            rd_busy = 1'b0;
            dst_base = '0;
            req_bytes = '0;
            bytes_issued = '0;
            first_word = '0;
            cur_sector = '0;
            prev_cmd = '0;
            resend_count = '0;
            result_q.delete();
            mismatches = 0;
            direct_cmds = 0;
            bounce_cmds = 0;
            resent_cmds = 0;
            finished_reads = 0;
            awaited <= 0;
            read_open <= 1'b0;
        end
        else begin
            if (cfg_we) begin
                if (cfg_index == CFG_BASE)
                    base_words = cfg_wdata;
                else
                    offs_in_words = cfg_wdata[0];
            end
            if (req_valid && req_ready)
                result_q.push_back(predict_result(req_item));
            if (rsp_valid && rsp_ready) begin
                if (result_q.size() == 0)
                    report_mismatch("result with nothing pending", 32'(rsp_item.action), 32'd0);
                else begin
                    want = result_q.pop_front();
                    check_field("action", 32'(rsp_item.action), 32'(want.action));
                    check_field("is_retry", 32'(rsp_item.is_retry), 32'(want.is_retry));
                    check_field("cmd_dest_address", rsp_item.cmd_dest_address,
                                want.cmd_dest_address);
                    check_field("cmd_lba", 32'(rsp_item.cmd_lba), 32'(want.cmd_lba));
                    check_field("cmd_byte_count", 32'(rsp_item.cmd_byte_count),
                                32'(want.cmd_byte_count));
                    check_field("copy_offset", 32'(rsp_item.copy_offset), 32'(want.copy_offset));
                    check_field("copy_count", 32'(rsp_item.copy_count), 32'(want.copy_count));
                    check_field("final_status", 32'(rsp_item.final_status),
                                32'(want.final_status));
                    if (want.is_retry)
                        resent_cmds = resent_cmds + 1;
                    else if (want.action == ACT_DIRECT)
                        direct_cmds = direct_cmds + 1;
                    else if (want.action == ACT_BOUNCE)
                        bounce_cmds = bounce_cmds + 1;
                    else if (want.action == ACT_FINISHED)
                        finished_reads = finished_reads + 1;
                end
            end
            awaited <= result_q.size();
            read_open <= rd_busy;
        end
    end

endmodule

// ===== bench/disc_read_chunk_sequencer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disc_read_chunk_sequencer_core_tb
// Stimulus and verdict for the disc read chunk sequencer.
// ----------------------------------------------------------------------------
// Drives read requests and drive completions into the block, with random
// idling on both channels, and leaves prediction and comparison to the
// checker beside it. A directed opening hits the special cases; then random
// read sequences run under six register settings, including the extremes.
// ----------------------------------------------------------------------------
module disc_read_chunk_sequencer_core_tb;
    import drcs_pkg::*;

    localparam int MAX_RETRIES  = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 80;   // result-side stall that backs up req
    localparam int PHASE_ITEMS  = 150;  // request items per random phase
    localparam int MAX_CMDS     = 40;   // completions before a read is aborted
    localparam int DRAIN_CYCLES = 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [31:0] cfg_wdata;

    drcs_stream_if #(.payload_t(in_item_t))  req_ch ();
    drcs_stream_if #(.payload_t(out_item_t)) rsp_ch ();

    // from the checker
    int unsigned mismatches;
    int unsigned awaited;
    logic        read_open;
    int unsigned direct_cmds;
    int unsigned bounce_cmds;
    int unsigned resent_cmds;
    int unsigned finished_reads;

    // stimulus-side copy of the registers, used only to shape disc offsets
    logic [31:0] cur_base = '0;
    logic        cur_in_words = 1'b0;

    bit          gaps_on = 1'b1;
    int unsigned items_sent = 0;
    int unsigned cycles = 0;

    // receiver state: long holds are requested by count, served here
    int unsigned hold_asks = 0;
    int unsigned holds_done = 0;
    int unsigned hold_left = 0;
    int unsigned stall_left = 0;

    disc_read_chunk_sequencer_core #(
        .MAX_RETRIES(MAX_RETRIES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    drcs_read_checker #(
        .MAX_RETRIES(MAX_RETRIES)
    ) read_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_ch.valid),
        .req_ready     (req_ch.ready),
        .req_item      (req_ch.payload),
        .rsp_valid     (rsp_ch.valid),
        .rsp_ready     (rsp_ch.ready),
        .rsp_item      (rsp_ch.payload),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .awaited       (awaited),
        .read_open     (read_open),
        .direct_cmds   (direct_cmds),
        .bounce_cmds   (bounce_cmds),
        .resent_cmds   (resent_cmds),
        .finished_reads(finished_reads)
    );

    always #5 clk = ~clk;

    // Watchdog: a hung handshake or a result that never shows up ends here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("disc_read_chunk_sequencer_core_tb: errors");
            $finish;
        end
    end

    initial rsp_ch.ready = 1'b0;

    // Result side. A long hold has priority; otherwise short random stalls
    // while gaps are enabled, else always ready.
    always @(posedge clk)
    begin
        if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_asks != holds_done) begin
            rsp_ch.ready <= 1'b0;
            hold_left <= LONG_HOLD - 1;
            holds_done <= holds_done + 1;
        end
        else if (stall_left != 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (gaps_on && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end
        else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // Offer one item and return at the edge that takes it. An optional idle gap
    // goes in front while gaps are enabled.
    task automatic send_item(input in_item_t it);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.payload <= it;
        do
            @(posedge clk);
        while (!req_ch.ready);
        items_sent = items_sent + 1;
    endtask

    task automatic send_start(input logic [31:0] dest, input logic [31:0] len,
                              input logic [31:0] off);
        in_item_t it;
        it.mode = MODE_START;
        it.dest_address = dest;
        it.request_length = len;
        it.disc_offset = off;
        it.drive_status = 8'($urandom());  // don't-care on a start
        send_item(it);
    endtask

    task automatic send_done(input logic [7:0] status);
        in_item_t it;
        it.mode = MODE_COMPLETE;
        it.dest_address = $urandom();      // start fields are don't-care here
        it.request_length = $urandom();
        it.disc_offset = $urandom();
        it.drive_status = status;
        send_item(it);
    endtask

    // Drop valid and wait until every predicted result has been taken.
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited != 0);
    endtask

    // Both registers written back to back; only called with the block idle.
    task automatic set_config(input logic [31:0] base, input logic in_words);
        cfg_we <= 1'b1;
        cfg_index <= CFG_BASE;
        cfg_wdata <= base;
        @(posedge clk);
        cfg_index <= CFG_UNSHIFTED;
        cfg_wdata <= {31'd0, in_words};
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_base = base;
        cur_in_words = in_words;
    endtask

    // Mostly "continue", with some drive errors (resend) and odd failures.
    function automatic logic [7:0] pick_status();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 82)
            return STATUS_CONTINUE;
        if (r < 95)
            return {7'($urandom_range(0, 127)), 1'b0};
        return {7'($urandom_range(1, 127)), 1'b1};
    endfunction

    function automatic logic [31:0] pick_dest();
        case ($urandom_range(0, 3))
            0, 1:    // DMA capable: 32-byte aligned below the window end
                return ($urandom() & 32'hF000_0000) | ($urandom_range(0, 32'h000B_FFFF) << 5);
            2:       // right at the end of the DMA window
                return 32'h0180_0000 - ($urandom_range(1, 200) << 5);
            default:
                return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return 32'd0;
        if (r < 40)
            return $urandom_range(1, 4096);
        if (r < 70)
            return $urandom_range(1, 8) << 11;
        if (r < 90)
            return $urandom_range(4097, 65536);
        if (r < 97)
            return $urandom_range(32'h007F_0000, 32'h0180_0000);
        return $urandom();
    endfunction

    // Pick the word the read should start at, then back out the request
    // offset for the current register setting. In byte mode the top two bits
    // of the word distance get lost, but the position within the sector
    // survives since 2^30 is a multiple of 512.
    function automatic logic [31:0] pick_offset();
        logic [31:0] word;
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6)
            word = $urandom() & 32'hFFFF_FE00;
        else if (r < 9)
            word = $urandom();
        else
            word = 32'hFFFF_FE00 | $urandom_range(0, 511);  // sector number wraps
        if (cur_in_words)
            return word - cur_base;
        return ((word - cur_base) << 2) | $urandom_range(0, 3);
    endfunction

    // One read from start to finish. read_open trails by one item, so the
    // loop stops one completion late; that last one lands on an idle block
    // and is ignored. Runaway reads get an odd failure status to close them.
    task automatic run_read(input logic [31:0] dest, input logic [31:0] len,
                            input logic [31:0] off);
        int n;
        send_start(dest, len, off);
        n = 0;
        do
        begin
            if ($urandom_range(0, 39) == 0)
                send_start($urandom(), pick_length(), $urandom());  // mostly rejected
            send_done(pick_status());
            n++;
        end
        while (read_open && n < MAX_CMDS);
        if (n >= MAX_CMDS)
            send_done({7'($urandom_range(1, 127)), 1'b1});
    endtask

    initial
    begin
        logic [31:0] phase_base[6];
        logic        phase_words[6];
        int unsigned quota;

        cfg_we <= 1'b0;
        cfg_index <= CFG_BASE;
        cfg_wdata <= '0;
        req_ch.valid <= 1'b0;
        req_ch.payload <= '0;

        phase_base[0] = 32'hFFFF_FFFF;  phase_words[0] = 1'b1;
        phase_base[1] = 32'h0000_0000;  phase_words[1] = 1'b1;
        phase_base[2] = $urandom();     phase_words[2] = 1'b0;
        phase_base[3] = 32'h0000_0200;  phase_words[3] = 1'b0;
        phase_base[4] = $urandom();     phase_words[4] = 1'b1;
        phase_base[5] = 32'hFFFF_FFFF;  phase_words[5] = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed opening, registers at their reset values ----
        // completion with no read open
        send_done(STATUS_CONTINUE);
        // zero length finishes on the start itself
        send_start(32'h0000_1000, 32'd0, 32'd0);
        // direct read capped at the chunk limit, then the tail as direct
        send_start(32'h0000_1000, 32'h0090_0000, 32'd0);
        send_done(STATUS_CONTINUE);
        send_done(STATUS_CONTINUE);
        // target one sector below the window end: too little room, bounce
        send_start(32'h017F_F800, 32'd4096, 32'd0);
        send_done(STATUS_CONTINUE);
        send_done(STATUS_CONTINUE);
        // unaligned target and a start word inside the sector
        send_start(32'h8000_0003, 32'd3000, 32'h0000_0123);
        send_done(STATUS_CONTINUE);
        send_done(STATUS_CONTINUE);
        // start while busy is rejected; odd failure status ends the read
        send_start(32'h0000_0100, 32'd2048, 32'd0);
        send_start(32'h0000_0200, 32'd4096, 32'd0);
        send_done(8'h03);
        // drive errors: resend until the retry budget is spent, then finish
        send_start(32'h0000_0004, 32'd100, 32'd0);
        send_done(8'h00);
        send_done(8'hFE);
        repeat (MAX_RETRIES - 2)
            send_done({7'($urandom_range(0, 127)), 1'b0});
        send_done(8'h00);
        // every field at its top value
        send_start(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_done(8'hFF);
        wait_idle();

        // ---- random phases, one register setting each ----
        for (int p = 0; p < 6; p++) begin
            set_config(phase_base[p], phase_words[p]);
            if (p == 2)
                hold_asks <= hold_asks + 1;   // sender keeps offering meanwhile
            if (p == 5)
                gaps_on = 1'b0;               // last stretch at full rate
            quota = items_sent + PHASE_ITEMS;
            while (items_sent < quota) begin
                if ($urandom_range(0, 9) == 0)
                    send_done(8'($urandom()));  // stray completion, read closed
                run_read(pick_dest(), pick_length(), pick_offset());
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d request items: %0d direct, %0d bounce, %0d resent commands,",
                 items_sent, direct_cmds, bounce_cmds, resent_cmds);
        $display("%0d reads finished over six register settings plus reset defaults",
                 finished_reads);
        if (mismatches == 0)
            $display("disc_read_chunk_sequencer_core_tb: clean");
        else
            $display("disc_read_chunk_sequencer_core_tb: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/drcs_pkg.sv
hdl/drcs_stream_if.sv
hdl/drcs_cmd_calc.sv
hdl/drcs_seq_ctrl.sv
hdl/disc_read_chunk_sequencer_core.sv
bench/drcs_read_checker.sv
bench/disc_read_chunk_sequencer_core_tb.sv
